[design/los_pkg.sv]
// Shared types, codes and default sizes for the 3D line-of-sight block.
package los_pkg;

  // Default grid and cost sizes
  localparam int LOS_X_BITS    = 6;
  localparam int LOS_Y_BITS    = 6;
  localparam int LOS_Z_BITS    = 4;
  localparam int LOS_COST_BITS = 8;

  // Threshold register
  localparam int              THR_BITS  = 8;
  localparam logic [THR_BITS-1:0] THR_RESET = 8'd128;

  // Input item command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Dominant axis of a line
  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  // Walker sequencer states
  typedef enum logic [1:0] {
    WS_IDLE,
    WS_PCOST,
    WS_WALK,
    WS_DONE
  } walk_state_t;

  // Query result handed from the walker to the output register
  typedef struct packed {
    logic valid;
    logic clear;
  } los_result_t;

endpackage

[design/los_cost_mem.sv]
// Cost map storage: one write port, one registered read port.
module los_cost_mem #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/los_walker.sv]
// Line walk sequencer: steps the 3D Bresenham line and checks each map cell.
module los_walker #(
  parameter int X_BITS    = 6,
  parameter int Y_BITS    = 6,
  parameter int Z_BITS    = 4,
  parameter int COST_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [X_BITS-1:0]           par_x,
  input  logic [Y_BITS-1:0]           par_y,
  input  logic [Z_BITS-1:0]           par_z,
  input  logic [X_BITS-1:0]           chd_x,
  input  logic [Y_BITS-1:0]           chd_y,
  input  logic [Z_BITS-1:0]           chd_z,
  input  logic [los_pkg::THR_BITS-1:0] threshold,
  output logic                        rd_en,
  output logic [X_BITS+Y_BITS+Z_BITS-1:0] rd_addr,
  input  logic [COST_BITS-1:0]        rd_data,
  output logic                        idle,
  output los_pkg::los_result_t        res,
  input  logic                        res_take
);
  import los_pkg::*;

  localparam int MXY  = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int MAXB = (MXY > Z_BITS) ? MXY : Z_BITS;
  localparam int EW   = MAXB + 3;
  localparam int CW   = (COST_BITS > THR_BITS) ? COST_BITS : THR_BITS;

  walk_state_t state, state_next;

  // Walk registers
  logic [X_BITS-1:0]    cx;
  logic [Y_BITS-1:0]    cy;
  logic [Z_BITS-1:0]    cz;
  logic                 dirx, diry, dirz;
  axis_t                sel;
  logic signed [EW-1:0] ea, eb, dm2, da2, db2;
  logic [MAXB-1:0]      rem;
  logic [COST_BITS-1:0] pcost;
  logic                 clr;

  // Setup values from the query fields
  logic [X_BITS-1:0]    dx;
  logic [Y_BITS-1:0]    dy;
  logic [Z_BITS-1:0]    dz;
  logic [MAXB-1:0]      wdx, wdy, wdz;
  logic [MAXB-1:0]      dm_i, da_i, db_i;
  axis_t                sel_i;
  logic signed [EW-1:0] dm2_i, da2_i, db2_i;

  // Step values
  logic                 ma, mb, movex, movey, movez;
  logic [X_BITS-1:0]    nx;
  logic [Y_BITS-1:0]    ny;
  logic [Z_BITS-1:0]    nz;
  logic signed [EW-1:0] ea_next, eb_next;
  logic                 blocked, issue;

  // Deltas, directions and dominant axis at query start
  always_comb begin
    dx = (par_x >= chd_x) ? par_x - chd_x : chd_x - par_x;
    dy = (par_y >= chd_y) ? par_y - chd_y : chd_y - par_y;
    dz = (par_z >= chd_z) ? par_z - chd_z : chd_z - par_z;
    wdx = MAXB'(dx);
    wdy = MAXB'(dy);
    wdz = MAXB'(dz);
    if (wdx >= wdy && wdx >= wdz) begin
      sel_i = AX_X;
      dm_i  = wdx;
      da_i  = wdy;
      db_i  = wdz;
    end else if (wdy >= wdz) begin
      sel_i = AX_Y;
      dm_i  = wdy;
      da_i  = wdx;
      db_i  = wdz;
    end else begin
      sel_i = AX_Z;
      dm_i  = wdz;
      da_i  = wdx;
      db_i  = wdy;
    end
    dm2_i = EW'(dm_i) <<< 1;
    da2_i = EW'(da_i) <<< 1;
    db2_i = EW'(db_i) <<< 1;
  end

  // One Bresenham step from the current cell
  always_comb begin
    ma = !ea[EW-1];
    mb = !eb[EW-1];
    ea_next = ea - (ma ? dm2 : '0) + da2;
    eb_next = eb - (mb ? dm2 : '0) + db2;
    case (sel)
      AX_X: begin
        movex = 1'b1;
        movey = ma;
        movez = mb;
      end
      AX_Y: begin
        movex = ma;
        movey = 1'b1;
        movez = mb;
      end
      AX_Z: begin
        movex = ma;
        movey = mb;
        movez = 1'b1;
      end
      default: begin
        movex = 1'b0;
        movey = 1'b0;
        movez = 1'b0;
      end
    endcase
    nx = movex ? (dirx ? cx - X_BITS'(1) : cx + X_BITS'(1)) : cx;
    ny = movey ? (diry ? cy - Y_BITS'(1) : cy + Y_BITS'(1)) : cy;
    nz = movez ? (dirz ? cz - Z_BITS'(1) : cz + Z_BITS'(1)) : cz;
  end

  // Cell check on the data of the last issued read
  assign blocked = (CW'(rd_data) >= CW'(threshold)) || (rd_data > pcost);
  assign issue   = (rem != '0) &&
                   ((state == WS_PCOST) || (state == WS_WALK && !blocked));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      WS_IDLE:  if (start) state_next = WS_PCOST;
      WS_PCOST: state_next = (rem == '0) ? WS_DONE : WS_WALK;
      WS_WALK:  if (blocked || rem == '0) state_next = WS_DONE;
      WS_DONE:  if (res_take) state_next = WS_IDLE;
      default:  state_next = WS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    idle      = (state == WS_IDLE);
    rd_en     = start || issue;
    rd_addr   = start ? {par_z, par_y, par_x} : {nz, ny, nx};
    res.valid = (state == WS_DONE);
    res.clear = clr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    if (start && state == WS_IDLE) begin
      cx   <= chd_x;
      cy   <= chd_y;
      cz   <= chd_z;
      dirx <= par_x < chd_x;
      diry <= par_y < chd_y;
      dirz <= par_z < chd_z;
      sel  <= sel_i;
      dm2  <= dm2_i;
      da2  <= da2_i;
      db2  <= db2_i;
      ea   <= da2_i - EW'(dm_i);
      eb   <= db2_i - EW'(dm_i);
      rem  <= dm_i;
    end else if (issue) begin
      cx  <= nx;
      cy  <= ny;
      cz  <= nz;
      ea  <= ea_next;
      eb  <= eb_next;
      rem <= rem - MAXB'(1);
    end
    if (state == WS_PCOST) begin
      pcost <= rd_data;
      clr   <= 1'b1;
    end else if (state == WS_WALK && blocked) begin
      clr <= 1'b0;
    end
  end

endmodule

[design/grid_line_of_sight_3d.sv]
// Write item: the cell is stored at the accepting edge; the next item can follow in the next cycle.
// Query: the walker reads the parent cell's cost, then steps D cells from the child toward the
// parent (D = major-axis distance), checking each; a blocking cell ends the walk early.
// The result is registered onto out_valid and line_clear. Items are taken one at a time; a query
// holds the input closed until its result is taken, the walker reading one map cell per cycle.
// Reset: control and output valid are cleared, threshold returns to 128; map contents are
// undefined until written, with no clearing pass.
module grid_line_of_sight_3d #(
  parameter int X_BITS    = los_pkg::LOS_X_BITS,
  parameter int Y_BITS    = los_pkg::LOS_Y_BITS,
  parameter int Z_BITS    = los_pkg::LOS_Z_BITS,
  parameter int COST_BITS = los_pkg::LOS_COST_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  input  logic [X_BITS-1:0]            write_x,
  input  logic [Y_BITS-1:0]            write_y,
  input  logic [Z_BITS-1:0]            write_z,
  input  logic [COST_BITS-1:0]         write_cost,
  input  logic [X_BITS-1:0]            parent_x,
  input  logic [Y_BITS-1:0]            parent_y,
  input  logic [Z_BITS-1:0]            parent_z,
  input  logic [X_BITS-1:0]            child_x,
  input  logic [Y_BITS-1:0]            child_y,
  input  logic [Z_BITS-1:0]            child_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         line_clear,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [los_pkg::THR_BITS-1:0] cfg_data
);
  import los_pkg::*;

  localparam int AW = X_BITS + Y_BITS + Z_BITS;

  logic                in_fire, start, mem_we, rd_en, idle, res_take;
  logic [AW-1:0]       rd_addr;
  logic [COST_BITS-1:0] rd_data;
  logic [THR_BITS-1:0] dead_threshold;
  los_result_t         res;

  // Input handshake: items only while the walker is idle
  assign in_ready = idle;
  assign in_fire  = in_valid && in_ready;
  assign start    = in_fire && (cmd == CMD_QUERY);
  assign mem_we   = in_fire && (cmd == CMD_WRITE);

  // Threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dead_threshold <= cfg_data;
    end
  end

  los_cost_mem #(
    .AW(AW),
    .DW(COST_BITS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr({write_z, write_y, write_x}),
    .wdata(write_cost),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  los_walker #(
    .X_BITS   (X_BITS),
    .Y_BITS   (Y_BITS),
    .Z_BITS   (Z_BITS),
    .COST_BITS(COST_BITS)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .par_x    (parent_x),
    .par_y    (parent_y),
    .par_z    (parent_z),
    .chd_x    (child_x),
    .chd_y    (child_y),
    .chd_z    (child_z),
    .threshold(dead_threshold),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .idle     (idle),
    .res      (res),
    .res_take (res_take)
  );

  // Output register
  assign res_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      line_clear <= res.clear;
    end
  end

endmodule

[design/los_checker.sv]
// Port-level assertions for the line-of-sight block, bound to the top level.
module los_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic cmd,
  input logic out_valid,
  input logic out_ready,
  input logic line_clear
);
  import los_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_clear))
    else $error("result changed or dropped while stalled");

  // A query keeps the input closed while it walks
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_QUERY |=> !in_ready)
    else $error("input open right after a query");

  // A write item leaves the block ready for the next item
  a_write_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_WRITE |=> in_ready)
    else $error("write item stalled the input");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind grid_line_of_sight_3d los_checker u_los_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .line_clear(line_clear)
);
